// File: hw/rtl/ght_pkg.sv
`timescale 1ns / 1ps
package ght_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Handle layout: index [17:0], type [25:18], generation [31:26]
    localparam int HIDX_W   = 18;
    localparam int HLIM_W   = HIDX_W + 1;
    localparam int TYPE_W   = 8;
    localparam int GEN_W    = 6;
    localparam int OBJ_W    = 64;
    localparam int HANDLE_W = 32;

    // Request codes
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    // Result codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TYPE_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [HANDLE_W-1:0] handle_in;
        logic [OBJ_W-1:0]    object_word;
        logic [TYPE_W-1:0]   object_type;
    } ght_req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] handle_out;
        logic [OBJ_W-1:0]    object_out;
    } ght_res_t;

    // One table slot
    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic [TYPE_W-1:0] typ;
        logic [OBJ_W-1:0]  obj;
    } ght_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       stack_rd;
        logic       entry_rd_handle;
        logic       entry_rd_pop;
        logic       alloc_new;
        logic       alloc_pop;
        logic       check;
        logic       set_err;
        logic [1:0] err_code;
        logic       out_load;
    } ght_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_alloc;
        logic type_zero;
        logic stack_empty;
        logic hw_full;
        logic handle_ok;
        logic out_free;
    } ght_sts_t;

endpackage

// File: hw/rtl/ght_ctrl.sv
`timescale 1ns / 1ps
module ght_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ght_pkg::ght_sts_t sts,
    output ght_pkg::ght_cmd_t cmd
);
    import ght_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_ALLOC,
        S_CHECK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Sequence one request at a time
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.is_alloc) begin
                    if (sts.type_zero) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_TYPE_ZERO;
                        state_next   = S_DONE;
                    end else if (!sts.stack_empty) begin
                        cmd.stack_rd = 1'b1;
                        state_next   = S_POP;
                    end else if (!sts.hw_full) begin
                        cmd.alloc_new = 1'b1;
                        state_next    = S_DONE;
                    end else begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_FULL;
                        state_next   = S_DONE;
                    end
                end else if (sts.handle_ok) begin
                    cmd.entry_rd_handle = 1'b1;
                    state_next          = S_CHECK;
                end else begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_INVALID;
                    state_next   = S_DONE;
                end
            end
            S_POP: begin
                cmd.entry_rd_pop = 1'b1;
                state_next       = S_ALLOC;
            end
            S_ALLOC: begin
                cmd.alloc_pop = 1'b1;
                state_next    = S_DONE;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/ght_datapath.sv
`timescale 1ns / 1ps
module ght_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  ght_pkg::ght_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ght_pkg::ght_res_t m_data,
    input  ght_pkg::ght_cmd_t cmd,
    output ght_pkg::ght_sts_t sts
);
    import ght_pkg::*;

    ght_entry_t entry_mem [TABLE_DEPTH];
    logic [IDX_W-1:0] stack_mem [TABLE_DEPTH];

    ght_req_t         req_reg;
    ght_res_t         res_reg, res_next;
    ght_res_t         out_reg;
    logic             out_valid_reg;
    ght_entry_t       entry_rd_reg;
    logic [IDX_W-1:0] stack_rd_reg;
    logic [CNT_W-1:0] hw_reg, hw_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next;

    logic [HIDX_W-1:0] h_idx;
    logic [TYPE_W-1:0] h_type;
    logic [GEN_W-1:0]  h_gen;
    logic [IDX_W-1:0]  slot_idx;
    logic [IDX_W-1:0]  hw_idx;
    logic [CNT_W-1:0]  fcnt_dec;
    logic [IDX_W-1:0]  entry_rd_addr;
    logic              entry_we;
    logic [IDX_W-1:0]  entry_waddr;
    ght_entry_t        entry_wdata;
    logic              stack_we;
    logic              hit;

    // Split the request handle
    assign h_idx    = req_reg.handle_in[HIDX_W-1:0];
    assign h_type   = req_reg.handle_in[HIDX_W +: TYPE_W];
    assign h_gen    = req_reg.handle_in[HIDX_W+TYPE_W +: GEN_W];
    assign slot_idx = h_idx[IDX_W-1:0];
    assign hw_idx   = hw_reg[IDX_W-1:0];
    assign fcnt_dec = fcnt_reg - CNT_W'(1);

    // Report request class and occupancy
    assign sts.is_alloc    = (req_reg.action == ACT_ALLOC);
    assign sts.type_zero   = (req_reg.object_type == '0);
    assign sts.stack_empty = (fcnt_reg == '0);
    assign sts.hw_full     = (hw_reg == CNT_W'(TABLE_DEPTH));
    assign sts.handle_ok   = ((req_reg.action == ACT_FREE) || (req_reg.action == ACT_LOOKUP))
                             && (h_type != '0)
                             && ({1'b0, h_idx} < HLIM_W'(TABLE_DEPTH));
    assign sts.out_free    = !out_valid_reg || m_ready;

    // Slots at or above the high-water mark were never written and read as empty
    assign hit = (CNT_W'(slot_idx) < hw_reg)
                 && (entry_rd_reg.typ == h_type)
                 && (entry_rd_reg.gen == h_gen);

    assign entry_rd_addr = cmd.entry_rd_pop ? stack_rd_reg : slot_idx;

    // Commit table, stack and counters; form the result
    always_comb begin
        entry_we    = 1'b0;
        entry_waddr = slot_idx;
        entry_wdata = '0;
        stack_we    = 1'b0;
        hw_next     = hw_reg;
        fcnt_next   = fcnt_reg;
        res_next    = res_reg;
        if (cmd.set_err) begin
            res_next = '{status: cmd.err_code, handle_out: '0, object_out: '0};
        end
        if (cmd.alloc_new) begin
            entry_we    = 1'b1;
            entry_waddr = hw_idx;
            entry_wdata = '{gen: '0, typ: req_reg.object_type, obj: req_reg.object_word};
            hw_next     = hw_reg + CNT_W'(1);
            res_next    = '{status: ST_OK,
                            handle_out: {GEN_W'(0), req_reg.object_type, HIDX_W'(hw_idx)},
                            object_out: '0};
        end
        if (cmd.alloc_pop) begin
            entry_we    = 1'b1;
            entry_waddr = stack_rd_reg;
            entry_wdata = '{gen: entry_rd_reg.gen, typ: req_reg.object_type,
                            obj: req_reg.object_word};
            fcnt_next   = fcnt_dec;
            res_next    = '{status: ST_OK,
                            handle_out: {entry_rd_reg.gen, req_reg.object_type,
                                         HIDX_W'(stack_rd_reg)},
                            object_out: '0};
        end
        if (cmd.check) begin
            if (hit) begin
                res_next = '{status: ST_OK, handle_out: '0,
                             object_out: (req_reg.action == ACT_LOOKUP) ? entry_rd_reg.obj
                                                                       : '0};
                if (req_reg.action == ACT_FREE) begin
                    entry_we    = 1'b1;
                    entry_wdata = '{gen: entry_rd_reg.gen + GEN_W'(1), typ: '0, obj: '0};
                    if (fcnt_reg != CNT_W'(TABLE_DEPTH)) begin
                        stack_we  = 1'b1;
                        fcnt_next = fcnt_reg + CNT_W'(1);
                    end
                end
            end else begin
                res_next = '{status: ST_INVALID, handle_out: '0, object_out: '0};
            end
        end
    end

    // Table memory
    always_ff @(posedge aclk) begin
        if (entry_we) begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        if (cmd.entry_rd_handle || cmd.entry_rd_pop) begin
            entry_rd_reg <= entry_mem[entry_rd_addr];
        end
    end

    // Free stack memory
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[fcnt_reg[IDX_W-1:0]] <= slot_idx;
        end
        if (cmd.stack_rd) begin
            stack_rd_reg <= stack_mem[fcnt_dec[IDX_W-1:0]];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_data;
        end
        res_reg <= res_next;
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg        <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            hw_reg   <= hw_next;
            fcnt_reg <= fcnt_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: hw/rtl/generational_handle_table.sv
`timescale 1ns / 1ps
// Generational handle table.
// Input channel (s_valid/s_ready/s_data) takes one request: allocate, free or
// lookup. Result channel (m_valid/m_ready/m_data) returns one result per
// request, in request order.
// Allocate from the high-water mark and requests refused without a table read
// (type zero, table full, unknown action, type-zero or out-of-range handle)
// go from decode straight to the result; free and lookup read the table
// first, and allocate from the free stack reads the stack, then the table
// entry of the popped slot. One request is in flight at a time and the input
// is ready again in the cycle after the result is loaded, so a new request
// is not taken until the last one's result is loaded; the pace is set by the
// sequential controller and the registered table and free-stack reads.
// Reset (aresetn low, synchronous) clears the high-water mark, the free-stack
// count and the result valid; slots at or above the high-water mark read as empty,
// so no clearing pass is needed and requests are taken right after reset.
// When the receiver stalls, the result is held in the output register; one
// further request is accepted and processed, and its result waits until the
// output register is taken.
module generational_handle_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ght_pkg::ght_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ght_pkg::ght_res_t m_data
);
    import ght_pkg::*;

    ght_cmd_t cmd;
    ght_sts_t sts;

    ght_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ght_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

// File: hw/rtl/ght_checker.sv
`timescale 1ns / 1ps
module ght_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input ght_pkg::ght_req_t s_data,
    input logic              m_valid,
    input logic              m_ready,
    input ght_pkg::ght_res_t m_data
);
    import ght_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // One request in flight: no back-to-back input transfers
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a request is in flight");

    // No result appears the cycle after an input transfer
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result produced too early");

    // Failed requests carry no handle and no object
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |->
            (m_data.handle_out == '0) && (m_data.object_out == '0))
        else $error("failed request carries data");

    // A returned handle has a nonzero type and no object
    a_handle_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.handle_out != '0) |->
            (m_data.status == ST_OK) && (m_data.handle_out[HIDX_W +: TYPE_W] != '0)
            && (m_data.object_out == '0))
        else $error("bad handle in result");

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);
